### src/lidar_packet_checksum_parser_unit_defines.svh
// Assertion macros shared by the packet parser RTL
`ifndef LIDAR_PACKET_CHECKSUM_PARSER_UNIT_DEFINES_SVH
`define LIDAR_PACKET_CHECKSUM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define LPCP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser check failed");

// Next-cycle implication, disabled while reset is high
`define LPCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser check failed");

`endif

### src/lpcp_pkg.sv
// Shared constants and types of the packet checksum parser
package lpcp_pkg;

   // Packet framing
   localparam logic [7:0] START_BYTE = 8'hFA;
   localparam logic [7:0] INDEX_LOW  = 8'hA0;
   localparam logic [7:0] INDEX_HIGH = 8'hF9;

   // Checksum fold
   localparam int FOLD_SHIFT = 15;

   // Word counter
   localparam int COUNT_W                = 4;
   localparam int WORDS_PER_PACKET_DEF   = 10;

   // Per-byte status from the parser core to the top level
   typedef struct packed {
      logic        done;
      logic [15:0] speed_word;
      logic        checksum_pass;
   } lpcp_status_type;

endpackage

### src/lpcp_parser.sv
// Packet parser core: framing state machine, running sum and checksum fold
`include "lidar_packet_checksum_parser_unit_defines.svh"

module lpcp_parser #(
   parameter int WORDS_PER_PACKET = lpcp_pkg::WORDS_PER_PACKET_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               rx_byte,
   output lpcp_pkg::lpcp_status_type status
);

   typedef enum logic [2:0] {
      PH_SEARCH   = 3'd0,
      PH_INDEX    = 3'd1,
      PH_SPEED_LO = 3'd2,
      PH_SPEED_HI = 3'd3,
      PH_WORD_LO  = 3'd4,
      PH_WORD_HI  = 3'd5,
      PH_SUM_LO   = 3'd6,
      PH_SUM_HI   = 3'd7
   } phase_type;

   localparam int CW = lpcp_pkg::COUNT_W;

   phase_type         phase_ff, phase_in;
   logic [31:0]       sum_ff, sum_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [15:0]       speed_ff, speed_in;
   logic [7:0]        low_ff, low_in;

   logic [15:0]       word;
   logic [31:0]       shift_add;
   logic [16:0]       fold_sum;
   logic [14:0]       folded;
   logic [CW:0]       next_count;
   logic [15:0]       speed_full;
   logic              index_ok;

   // Datapath pieces
   assign word       = {rx_byte, low_ff};
   assign speed_full = {rx_byte, speed_ff[7:0]};
   assign fold_sum   = {2'b00, sum_ff[lpcp_pkg::FOLD_SHIFT-1:0]}
                     + sum_ff[31:lpcp_pkg::FOLD_SHIFT];
   assign folded     = fold_sum[14:0];
   assign next_count = {1'b0, count_ff} + (CW+1)'(1);
   assign index_ok   = (rx_byte >= lpcp_pkg::INDEX_LOW) && (rx_byte <= lpcp_pkg::INDEX_HIGH);

   always_comb begin
      shift_add = {sum_ff[30:0], 1'b0};
      if (phase_ff == PH_SPEED_HI) begin
         shift_add = shift_add + {16'd0, speed_full};
      end else begin
         shift_add = shift_add + {16'd0, word};
      end
   end

   // Result of the byte now presented
   always_comb begin
      status.done          = (phase_ff == PH_SUM_HI);
      status.speed_word    = speed_ff;
      status.checksum_pass = ({1'b0, folded} == word);
   end

   // Next-state logic
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      speed_in = speed_ff;
      low_in   = low_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (rx_byte == lpcp_pkg::START_BYTE) phase_in = PH_INDEX;
         end
         PH_INDEX: begin
            if (index_ok) begin
               sum_in   = {16'd0, rx_byte, lpcp_pkg::START_BYTE};
               phase_in = PH_SPEED_LO;
            end else if (rx_byte != lpcp_pkg::START_BYTE) begin
               phase_in = PH_SEARCH;
            end
         end
         PH_SPEED_LO: begin
            speed_in = {8'd0, rx_byte};
            phase_in = PH_SPEED_HI;
         end
         PH_SPEED_HI: begin
            speed_in = speed_full;
            count_in = CW'(2);
            sum_in   = shift_add;
            phase_in = (2 >= WORDS_PER_PACKET) ? PH_SUM_LO : PH_WORD_LO;
         end
         PH_WORD_LO: begin
            low_in   = rx_byte;
            phase_in = PH_WORD_HI;
         end
         PH_WORD_HI: begin
            sum_in   = shift_add;
            count_in = next_count[CW-1:0];
            phase_in = (next_count >= (CW+1)'(WORDS_PER_PACKET)) ? PH_SUM_LO : PH_WORD_LO;
         end
         PH_SUM_LO: begin
            low_in   = rx_byte;
            phase_in = PH_SUM_HI;
         end
         PH_SUM_HI: begin
            sum_in   = {17'd0, folded};
            phase_in = PH_SEARCH;
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase
   end

   // State registers, advanced once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         sum_ff   <= '0;
         count_ff <= '0;
         speed_ff <= '0;
         low_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         speed_ff <= speed_in;
         low_ff   <= low_in;
      end
   end

   // Checks
   `LPCP_ASSERT_NEXT(a_end_returns_search, clock, reset,
      step_en && (phase_ff == PH_SUM_HI), phase_ff == PH_SEARCH && sum_ff[31:15] == 17'd0)
   `LPCP_ASSERT_NOW(a_count_in_range, clock, reset,
      (phase_ff == PH_WORD_LO) || (phase_ff == PH_WORD_HI),
      ({1'b0, count_ff} >= (CW+1)'(2)) && ({1'b0, count_ff} < (CW+1)'(WORDS_PER_PACKET)))
   `LPCP_ASSERT_NEXT(a_index_seeds_sum, clock, reset,
      step_en && (phase_ff == PH_INDEX) && index_ok,
      phase_ff == PH_SPEED_LO && sum_ff[31:16] == 16'd0)

endmodule

### src/lidar_packet_checksum_parser_unit.sv
// Top level of the serial packet checksum parser
//
// Takes one received byte per item and emits one item per completed packet:
// the little-endian speed word and a flag that the 15-bit folded running
// sum matched the packet checksum. One byte is accepted every cycle unless
// a final byte waits; a byte is held in an input register and processed
// by the parser core from there, and a packet's result is registered in
// the output register before it is offered. Only a packet's final byte
// waits, and only while an earlier result still sits untaken there.
module lidar_packet_checksum_parser_unit #(
   parameter int WORDS_PER_PACKET = lpcp_pkg::WORDS_PER_PACKET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_speed_word,
   output logic        rsp_checksum_pass
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      rsp_valid_ff;
   logic [15:0]               speed_ff;
   logic                      pass_ff;
   logic                      advance;
   lpcp_pkg::lpcp_status_type status;

   // Core processes the held byte unless its result has nowhere to go
   assign advance   = in_valid_ff && (!status.done || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   lpcp_parser #(
      .WORDS_PER_PACKET(WORDS_PER_PACKET)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .status  (status)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && status.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.done) begin
         speed_ff <= status.speed_word;
         pass_ff  <= status.checksum_pass;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_word    = speed_ff;
   assign rsp_checksum_pass = pass_ff;

endmodule

### tb/testbench.sv
// Self-checking testbench for the serial packet checksum parser
`timescale 1ns / 1ps

module testbench;

   localparam int WORDS          = lpcp_pkg::WORDS_PER_PACKET_DEF;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_BYTES   = 1350;
   localparam logic [31:0] FOLD_MASK = 32'h0000_7FFF;

   // Parser phases, one per expected byte position
   typedef enum logic [2:0] {
      PARSE_SEARCH   = 3'd0,
      PARSE_INDEX    = 3'd1,
      PARSE_SPEED_LO = 3'd2,
      PARSE_SPEED_HI = 3'd3,
      PARSE_WORD_LO  = 3'd4,
      PARSE_WORD_HI  = 3'd5,
      PARSE_SUM_LO   = 3'd6,
      PARSE_SUM_HI   = 3'd7
   } parse_phase_type;

   typedef struct packed {
      logic [15:0] speed;
      logic        pass;
   } packet_result_type;

   // Directed row: one byte, plus a hand-written result where one is obvious
   typedef struct packed {
      logic [7:0]  rx_val;
      logic        typed;
      logic [15:0] speed;
      logic        pass;
   } rx_row_type;

   // Noise, bad indexes both sides, repeated start, then a packet with
   // all-ones speed, start bytes inside the data and a checksum with bit 15
   // set, which the 15-bit fold can never match
   localparam rx_row_type DIRECTED [28] = '{
      '{8'h00, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'h9F, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'hFB, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'hF9, 1'b0, 16'h0000, 1'b0},
      '{8'hFF, 1'b0, 16'h0000, 1'b0},
      '{8'hFF, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'h00, 1'b0, 16'h0000, 1'b0},
      '{8'hFF, 1'b0, 16'h0000, 1'b0},
      '{8'hFF, 1'b0, 16'h0000, 1'b0},
      '{8'h00, 1'b0, 16'h0000, 1'b0},
      '{8'h00, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'hFA, 1'b0, 16'h0000, 1'b0},
      '{8'h55, 1'b0, 16'h0000, 1'b0},
      '{8'hAA, 1'b0, 16'h0000, 1'b0},
      '{8'hAA, 1'b0, 16'h0000, 1'b0},
      '{8'h55, 1'b0, 16'h0000, 1'b0},
      '{8'h01, 1'b0, 16'h0000, 1'b0},
      '{8'h80, 1'b0, 16'h0000, 1'b0},
      '{8'h80, 1'b0, 16'h0000, 1'b0},
      '{8'h01, 1'b0, 16'h0000, 1'b0},
      '{8'h00, 1'b0, 16'h0000, 1'b0},
      '{8'h80, 1'b1, 16'hFFFF, 1'b0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_speed_word;
   logic        rsp_checksum_pass;

   // Parser shadow state
   parse_phase_type   parse_phase;
   logic [31:0]       fold_acc;
   logic [3:0]        words_seen;
   logic [15:0]       speed_latch;
   logic [7:0]        low_latch;

   packet_result_type packet_results_q [$];
   logic              row_typed;
   packet_result_type row_result;
   int                error_count;
   int                stall_cycles;
   int                bytes_sent;
   int                send_idle_pct;
   int                recv_idle_pct;

   lidar_packet_checksum_parser_unit #(
      .WORDS_PER_PACKET(WORDS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speed_word   (rsp_speed_word),
      .rsp_checksum_pass(rsp_checksum_pass)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advance the shadow parser by one accepted byte; queue the packet result
   function automatic void parse_byte(input logic [7:0] rx);
      logic [15:0]       word;
      logic [31:0]       folded;
      logic [4:0]        next_count;
      packet_result_type res;
      case (parse_phase)
         PARSE_SEARCH: begin
            if (rx == lpcp_pkg::START_BYTE) parse_phase = PARSE_INDEX;
         end
         PARSE_INDEX: begin
            if (rx >= lpcp_pkg::INDEX_LOW && rx <= lpcp_pkg::INDEX_HIGH) begin
               fold_acc    = {16'h0000, rx, lpcp_pkg::START_BYTE};
               parse_phase = PARSE_SPEED_LO;
            end else if (rx != lpcp_pkg::START_BYTE) begin
               parse_phase = PARSE_SEARCH;
            end
         end
         PARSE_SPEED_LO: begin
            speed_latch = {8'h00, rx};
            parse_phase = PARSE_SPEED_HI;
         end
         PARSE_SPEED_HI: begin
            speed_latch = {rx, speed_latch[7:0]};
            words_seen  = 4'd2;
            fold_acc    = (fold_acc << 1) + {16'h0000, speed_latch};
            parse_phase = (WORDS <= 2) ? PARSE_SUM_LO : PARSE_WORD_LO;
         end
         PARSE_WORD_LO: begin
            low_latch   = rx;
            parse_phase = PARSE_WORD_HI;
         end
         PARSE_WORD_HI: begin
            word        = {rx, low_latch};
            fold_acc    = (fold_acc << 1) + {16'h0000, word};
            next_count  = {1'b0, words_seen} + 5'd1;
            words_seen  = next_count[3:0];
            parse_phase = (next_count >= WORDS) ? PARSE_SUM_LO : PARSE_WORD_LO;
         end
         PARSE_SUM_LO: begin
            low_latch   = rx;
            parse_phase = PARSE_SUM_HI;
         end
         default: begin
            word        = {rx, low_latch};
            folded      = ((fold_acc & FOLD_MASK) + (fold_acc >> lpcp_pkg::FOLD_SHIFT))
                          & FOLD_MASK;
            fold_acc    = folded;
            parse_phase = PARSE_SEARCH;
            res.speed   = speed_latch;
            res.pass    = (folded[15:0] == word);
            packet_results_q.push_back(row_typed ? row_result : res);
         end
      endcase
   endfunction

   // Folded checksum of a well-formed packet, for building stimulus
   function automatic logic [15:0] packet_checksum(input logic [7:0] idx,
                                                   input logic [15:0] words[$]);
      logic [31:0] acc;
      acc = {16'h0000, idx, lpcp_pkg::START_BYTE};
      foreach (words[i]) acc = (acc << 1) + {16'h0000, words[i]};
      acc = ((acc & FOLD_MASK) + (acc >> lpcp_pkg::FOLD_SHIFT)) & FOLD_MASK;
      return acc[15:0];
   endfunction

   // Offer one byte; called and returning at a falling edge
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return 16'h0000;
      if (pick < 10) return 16'hFFFF;
      if (pick < 14) return {8'h00, lpcp_pkg::START_BYTE};
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [7:0] random_index();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return lpcp_pkg::INDEX_LOW;
      if (pick < 20) return lpcp_pkg::INDEX_HIGH;
      return 8'($urandom_range(lpcp_pkg::INDEX_HIGH, lpcp_pkg::INDEX_LOW));
   endfunction

   // One start, index, speed, data words and checksum; optionally corrupted
   task automatic send_packet(input bit good_sum, input int cut_after);
      logic [15:0] words[$];
      logic [15:0] sum_word;
      logic [7:0]  idx;
      int          n;
      idx = random_index();
      for (int i = 0; i < WORDS - 1; i++) words.push_back(random_word());
      sum_word = packet_checksum(idx, words);
      if (!good_sum) begin
         if ($urandom_range(1)) sum_word = sum_word ^ (16'h1 << $urandom_range(15));
         else sum_word = 16'($urandom_range(65535));
      end
      words.push_back(sum_word);
      if ($urandom_range(99) < 20) send_byte(lpcp_pkg::START_BYTE);
      send_byte(lpcp_pkg::START_BYTE);
      send_byte(idx);
      n = 0;
      foreach (words[i]) begin
         if (cut_after > 0 && n >= cut_after) return;
         send_byte(words[i][7:0]);
         send_byte(words[i][15:8]);
         n++;
      end
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Predict on every accepted byte, check every accepted result, watchdog
   always @(posedge clock) begin
      packet_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) parse_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (packet_results_q.size() == 0) begin
               $error("unexpected result: speed_word %h checksum_pass %b",
                      rsp_speed_word, rsp_checksum_pass);
               error_count++;
            end else begin
               want = packet_results_q.pop_front();
               if (rsp_speed_word !== want.speed) begin
                  $error("speed_word expected %h actual %h", want.speed, rsp_speed_word);
                  error_count++;
               end
               if (rsp_checksum_pass !== want.pass) begin
                  $error("checksum_pass expected %b actual %b",
                         want.pass, rsp_checksum_pass);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("testbench: done, errors");
               $finish;
            end
         end
      end
   end

   initial begin
      int pick;
      int target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      rsp_ready     = 1'b0;
      row_typed     = 1'b0;
      row_result    = '0;
      error_count   = 0;
      stall_cycles  = 0;
      bytes_sent    = 0;
      send_idle_pct = 7;
      recv_idle_pct = 60;
      parse_phase   = PARSE_SEARCH;
      fold_acc      = '0;
      words_seen    = '0;
      speed_latch   = '0;
      low_latch     = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed bytes
      foreach (DIRECTED[i]) begin
         row_typed  = DIRECTED[i].typed;
         row_result = '{DIRECTED[i].speed, DIRECTED[i].pass};
         send_byte(DIRECTED[i].rx_val);
      end
      row_typed = 1'b0;

      // Random traffic in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 7;  recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = bytes_sent + RANDOM_BYTES / 3;
         while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_packet(1'b1, 0);
            end else if (pick < 70) begin
               send_packet(1'b0, 0);
            end else if (pick < 75) begin
               // truncated packet; following bytes land inside it
               send_packet(1'b1, $urandom_range(WORDS - 1, 1));
            end else if (pick < 87) begin
               // start byte followed by an out-of-range index
               send_byte(lpcp_pkg::START_BYTE);
               pick = $urandom_range(255);
               while ((pick >= lpcp_pkg::INDEX_LOW && pick <= lpcp_pkg::INDEX_HIGH)
                      || pick == lpcp_pkg::START_BYTE)
                  pick = $urandom_range(255);
               send_byte(8'(pick));
            end else begin
               repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
            end
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then allow for stray late ones
      while (packet_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
